/* design/napt_pkg.sv */
`default_nettype none
package napt_pkg;

    // command codes
    localparam logic [2:0] CMD_OUTBOUND = 3'd0;
    localparam logic [2:0] CMD_INBOUND  = 3'd1;
    localparam logic [2:0] CMD_SWEEP    = 3'd2;
    localparam logic [2:0] CMD_QUERY    = 3'd3;
    localparam logic [2:0] CMD_HAIRPIN  = 3'd4;
    localparam logic [2:0] CMD_STATS    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_NOMAP   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_GATEWAY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBNET   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 8'd3;
    localparam logic [31:0] TIMEOUT_RESET = 32'd300000;

    localparam int IN_W  = 160;
    localparam int OUT_W = 248;

    // one table entry
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  proto;
        logic [31:0] last_seen;
        logic [63:0] packets;
        logic [63:0] bytes;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic start;
        logic init;
        logic scan_issue;
        logic port_rd;
        logic port_chk;
        logic commit;
        logic out_load;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       clear_last;
        logic       scan_last;
        logic       pre_fail;
        logic       port_hit;
        logic       out_free;
        logic [2:0] cmd;
    } dp_stat_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage
`default_nettype wire

/* design/napt_translation_table.sv */
// NAPT translation table. Outbound and query scan every slot and then commit; sweep
// and stats scan every slot; inbound reads the destination port slot; hairpin reads it
// and, on a mapping, scans and commits; rejects and spares go straight to the result.
// One item at a time: the next beat is taken once the result has loaded; the single
// table read port sets the slot scan; a held result stalls the input.
// Reset: synchronous active-low; a clearing pass empties every slot.
`default_nettype none
module napt_translation_table #(
    parameter int ENTRIES   = 256,
    parameter int PORT_BASE = 1024
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // cmd, src_addr, dst_addr, src_port_in, dst_port_in, proto, pkt_length, now_ticks
    input  wire  [napt_pkg::IN_W-1:0]        s_tdata,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // status, out_src_addr, out_src_port, out_dst_addr, out_dst_port,
    // active_entries, total_packets, total_bytes, freed_count
    output logic [napt_pkg::OUT_W-1:0]       m_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [napt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [31:0]                      cfg_data
);
    napt_pkg::ctl_cmd_t ctl;
    napt_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    napt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    napt_dpath #(
        .ENTRIES   (ENTRIES),
        .PORT_BASE (PORT_BASE)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

/* design/napt_ctrl.sv */
`default_nettype none
module napt_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  napt_pkg::dp_stat_t   stat,
    output napt_pkg::ctl_cmd_t   ctl
);
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_INIT    = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_SCANEND = 4'd4;
    localparam logic [3:0] S_PORT    = 4'd5;
    localparam logic [3:0] S_PORTCHK = 4'd6;
    localparam logic [3:0] S_COMMIT  = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLEAR;
        else          state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            S_CLEAR: begin
                ctl.clear_wr = 1'b1;
                if (stat.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.start  = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                ctl.init = 1'b1;
                case (stat.cmd)
                    napt_pkg::CMD_OUTBOUND: state_next = stat.pre_fail ? S_DONE : S_SCAN;
                    napt_pkg::CMD_INBOUND,
                    napt_pkg::CMD_HAIRPIN:  state_next = stat.pre_fail ? S_DONE : S_PORT;
                    napt_pkg::CMD_SWEEP,
                    napt_pkg::CMD_QUERY,
                    napt_pkg::CMD_STATS:    state_next = S_SCAN;
                    default:                state_next = S_DONE;
                endcase
            end
            S_SCAN: begin
                ctl.scan_issue = 1'b1;
                if (stat.scan_last) state_next = S_SCANEND;
            end
            S_SCANEND: begin
                if (stat.cmd inside {napt_pkg::CMD_OUTBOUND, napt_pkg::CMD_QUERY,
                                     napt_pkg::CMD_HAIRPIN})
                    state_next = S_COMMIT;
                else
                    state_next = S_DONE;
            end
            S_PORT: begin
                ctl.port_rd = 1'b1;
                state_next  = S_PORTCHK;
            end
            S_PORTCHK: begin
                ctl.port_chk = 1'b1;
                if (stat.cmd == napt_pkg::CMD_HAIRPIN && stat.port_hit) state_next = S_SCAN;
                else                                                    state_next = S_DONE;
            end
            S_COMMIT: begin
                ctl.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* design/napt_dpath.sv */
`default_nettype none
module napt_dpath #(
    parameter int ENTRIES   = 256,
    parameter int PORT_BASE = 1024
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  napt_pkg::ctl_cmd_t                ctl,
    output napt_pkg::dp_stat_t                stat,
    input  wire  [napt_pkg::IN_W-1:0]         s_tdata,
    input  wire                               cfg_valid,
    input  wire  [napt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [31:0]                       cfg_data,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [napt_pkg::OUT_W-1:0]        m_tdata
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [15:0]   BASE16   = 16'(PORT_BASE);
    localparam logic [16:0]   ENT17    = 17'(ENTRIES);

    // configuration
    logic [31:0] gw_reg, subnet_reg, mask_reg, timeout_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg      <= '0;
            subnet_reg  <= '0;
            mask_reg    <= '0;
            timeout_reg <= napt_pkg::TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                napt_pkg::REG_GATEWAY: gw_reg      <= cfg_data;
                napt_pkg::REG_SUBNET:  subnet_reg  <= cfg_data;
                napt_pkg::REG_MASK:    mask_reg    <= cfg_data;
                napt_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    logic [2:0]  cmd_reg;
    logic [31:0] sa_reg, da_reg, now_reg;
    logic [15:0] sp_reg, dp_reg, len_reg;
    logic [7:0]  pr_reg;
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            cmd_reg <= s_tdata[2:0];
            sa_reg  <= s_tdata[34:3];
            da_reg  <= s_tdata[66:35];
            sp_reg  <= s_tdata[82:67];
            dp_reg  <= s_tdata[98:83];
            pr_reg  <= s_tdata[106:99];
            len_reg <= s_tdata[122:107];
            now_reg <= s_tdata[154:123];
        end
    end

    logic pre_fail;
    always_comb begin
        case (cmd_reg)
            napt_pkg::CMD_OUTBOUND: pre_fail = ((sa_reg & mask_reg) != subnet_reg);
            napt_pkg::CMD_INBOUND,
            napt_pkg::CMD_HAIRPIN:  pre_fail = (da_reg != gw_reg);
            default:                pre_fail = 1'b0;
        endcase
    end

    // slot addressed by destination port
    logic [15:0] port_off;
    logic        port_inrange;
    assign port_off     = dp_reg - BASE16;
    assign port_inrange = ({1'b0, port_off} < ENT17);

    // table memory
    napt_pkg::entry_t mem [ENTRIES];
    napt_pkg::entry_t rd_data_reg, wr_data;
    logic [IW-1:0]    rd_addr, wr_addr;
    logic             rd_en, wr_en;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // scan and clear counters
    logic [IW-1:0] scan_idx_reg, clr_idx_reg, eval_idx_reg;
    logic          eval_vld_reg, port_inrange_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            clr_idx_reg  <= '0;
            eval_vld_reg <= 1'b0;
        end else begin
            if (ctl.clear_wr) clr_idx_reg <= clr_idx_reg + 1'b1;
            if (ctl.init || (ctl.port_chk)) scan_idx_reg <= '0;
            else if (ctl.scan_issue)        scan_idx_reg <= scan_idx_reg + 1'b1;
            eval_vld_reg <= ctl.scan_issue;
        end
    end
    always_ff @(posedge aclk) begin
        eval_idx_reg <= scan_idx_reg;
        if (ctl.port_rd) port_inrange_reg <= port_inrange;
    end

    assign rd_en   = ctl.scan_issue || ctl.port_rd;
    assign rd_addr = ctl.scan_issue ? scan_idx_reg : port_off[IW-1:0];

    // entry under evaluation
    logic key_match, expired, port_hit;
    assign key_match = rd_data_reg.valid && rd_data_reg.addr == sa_reg &&
                       rd_data_reg.port == sp_reg && rd_data_reg.proto == pr_reg;
    assign expired   = rd_data_reg.valid && ((now_reg - rd_data_reg.last_seen) > timeout_reg);
    assign port_hit  = port_inrange_reg && rd_data_reg.valid && rd_data_reg.proto == pr_reg;

    logic sweep_wr;
    assign sweep_wr = eval_vld_reg && cmd_reg == napt_pkg::CMD_SWEEP && expired;

    // scan results
    logic             hit_found_reg, free_found_reg;
    logic [IW-1:0]    hit_idx_reg, free_idx_reg;
    napt_pkg::entry_t hit_entry_reg;
    logic [LW-1:0]    live_reg, freed_reg;
    logic [63:0]      run_pkts_reg, run_bytes_reg;

    // result fields
    logic [1:0]  res_status_reg;
    logic [31:0] res_sa_reg, res_da_reg;
    logic [15:0] res_sp_reg, res_dp_reg;

    logic [15:0] hit_port, free_port;
    assign hit_port  = 16'(BASE16 + 16'(hit_idx_reg));
    assign free_port = 16'(BASE16 + 16'(free_idx_reg));

    logic commit_new;
    assign commit_new = ctl.commit && cmd_reg == napt_pkg::CMD_OUTBOUND &&
                        !hit_found_reg && free_found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg      <= '0;
            run_pkts_reg  <= '0;
            run_bytes_reg <= '0;
        end else begin
            if (commit_new) live_reg <= live_reg + 1'b1;
            else if (sweep_wr) live_reg <= live_reg - 1'b1;
            if (ctl.init && cmd_reg == napt_pkg::CMD_STATS) begin
                run_pkts_reg  <= '0;
                run_bytes_reg <= '0;
            end else if (eval_vld_reg && cmd_reg == napt_pkg::CMD_STATS &&
                         rd_data_reg.valid) begin
                run_pkts_reg  <= napt_pkg::sat_add64(run_pkts_reg, rd_data_reg.packets);
                run_bytes_reg <= napt_pkg::sat_add64(run_bytes_reg, rd_data_reg.bytes);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.init) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            freed_reg      <= '0;
            res_status_reg <= pre_fail ? napt_pkg::ST_REJECT : napt_pkg::ST_OK;
            if (cmd_reg inside {napt_pkg::CMD_OUTBOUND, napt_pkg::CMD_INBOUND,
                                napt_pkg::CMD_HAIRPIN}) begin
                res_sa_reg <= sa_reg;
                res_sp_reg <= sp_reg;
                res_da_reg <= da_reg;
                res_dp_reg <= dp_reg;
            end else begin
                res_sa_reg <= '0;
                res_sp_reg <= '0;
                res_da_reg <= '0;
                res_dp_reg <= '0;
            end
        end else begin
            // scan evaluation
            if (eval_vld_reg) begin
                if (key_match && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= eval_idx_reg;
                    hit_entry_reg <= rd_data_reg;
                end
                if (!rd_data_reg.valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= eval_idx_reg;
                end
                if (sweep_wr) freed_reg <= freed_reg + 1'b1;
            end
            // destination slot check
            if (ctl.port_chk) begin
                if (port_hit) begin
                    res_da_reg <= rd_data_reg.addr;
                    res_dp_reg <= rd_data_reg.port;
                end else begin
                    res_status_reg <= napt_pkg::ST_NOMAP;
                end
            end
            // key result
            if (ctl.commit) begin
                if (hit_found_reg) begin
                    res_sa_reg <= gw_reg;
                    res_sp_reg <= hit_port;
                end else if (cmd_reg == napt_pkg::CMD_OUTBOUND && free_found_reg) begin
                    res_sa_reg <= gw_reg;
                    res_sp_reg <= free_port;
                end else if (cmd_reg == napt_pkg::CMD_OUTBOUND) begin
                    res_status_reg <= napt_pkg::ST_FULL;
                end else if (cmd_reg == napt_pkg::CMD_QUERY) begin
                    res_status_reg <= napt_pkg::ST_NOMAP;
                end
            end
        end
    end

    // table write port
    logic port_touch, hit_touch;
    assign port_touch = ctl.port_chk && port_hit && cmd_reg == napt_pkg::CMD_INBOUND;
    assign hit_touch  = ctl.commit && cmd_reg == napt_pkg::CMD_OUTBOUND && hit_found_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        if (ctl.clear_wr) begin
            wr_en         = 1'b1;
            wr_addr       = clr_idx_reg;
            wr_data       = '0;
        end else if (sweep_wr) begin
            wr_en         = 1'b1;
            wr_addr       = eval_idx_reg;
            wr_data.valid = 1'b0;
        end else if (port_touch) begin
            wr_en             = 1'b1;
            wr_addr           = port_off[IW-1:0];
            wr_data.last_seen = now_reg;
            wr_data.packets   = napt_pkg::sat_add64(rd_data_reg.packets, 64'd1);
            wr_data.bytes     = napt_pkg::sat_add64(rd_data_reg.bytes, {48'd0, len_reg});
        end else if (hit_touch) begin
            wr_en             = 1'b1;
            wr_addr           = hit_idx_reg;
            wr_data           = hit_entry_reg;
            wr_data.last_seen = now_reg;
            wr_data.packets   = napt_pkg::sat_add64(hit_entry_reg.packets, 64'd1);
            wr_data.bytes     = napt_pkg::sat_add64(hit_entry_reg.bytes, {48'd0, len_reg});
        end else if (commit_new) begin
            wr_en             = 1'b1;
            wr_addr           = free_idx_reg;
            wr_data.valid     = 1'b1;
            wr_data.addr      = sa_reg;
            wr_data.port      = sp_reg;
            wr_data.proto     = pr_reg;
            wr_data.last_seen = now_reg;
            wr_data.packets   = 64'd1;
            wr_data.bytes     = {48'd0, len_reg};
        end
    end

    // output register
    logic                       m_tvalid_reg;
    logic [napt_pkg::OUT_W-1:0] m_tdata_reg;
    logic [31:0]                live_ext, freed_ext;
    logic                       is_stats;
    assign live_ext  = 32'(live_reg);
    assign freed_ext = 32'(freed_reg);
    assign is_stats  = (cmd_reg == napt_pkg::CMD_STATS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_tdata_reg <= {4'd0, freed_ext[8:0],
                            is_stats ? run_bytes_reg : 64'd0,
                            is_stats ? run_pkts_reg : 64'd0,
                            live_ext[8:0], res_dp_reg, res_da_reg,
                            res_sp_reg, res_sa_reg, res_status_reg};
        end
    end
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.clear_last = ctl.clear_wr && clr_idx_reg == LAST_IDX;
    assign stat.scan_last  = ctl.scan_issue && scan_idx_reg == LAST_IDX;
    assign stat.pre_fail   = pre_fail;
    assign stat.port_hit   = port_hit;
    assign stat.out_free   = !m_tvalid_reg || m_tready;
    assign stat.cmd        = cmd_reg;

    // checks
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= LW'(ENTRIES))
        else $error("live count above table size");
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.clear_wr, sweep_wr, port_touch, hit_touch, commit_new}))
        else $error("two table writers in one cycle");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before taken");
    a_new_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_new |-> live_reg < LW'(ENTRIES))
        else $error("new mapping with table full");

endmodule
`default_nettype wire

/* dv/tb_napt_translation_table.sv */
`timescale 1ns / 1ps
module tb_napt_translation_table;

    localparam int ENTRIES   = 256;
    localparam int PORT_BASE = 1024;
    localparam int LIMIT     = 3000000;
    localparam int DRAIN     = 300;
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    // input beat, first field in the low bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] now;
        logic [15:0] len;
        logic [7:0]  proto;
        logic [15:0] dp;
        logic [15:0] sp;
        logic [31:0] da;
        logic [31:0] sa;
        logic [2:0]  cmd;
    } item_t;

    // result beat
    typedef struct packed {
        logic [3:0]  pad;
        logic [8:0]  freed;
        logic [63:0] tbytes;
        logic [63:0] tpkts;
        logic [8:0]  active;
        logic [15:0] odp;
        logic [31:0] oda;
        logic [15:0] osp;
        logic [31:0] osa;
        logic [1:0]  status;
    } res_t;

    typedef struct {
        res_t       r;
        bit         known;
        logic [1:0] st;
        logic [8:0] act;
    } xlate_exp_t;

    typedef struct {
        item_t      it;
        bit         known;
        logic [1:0] st;
        logic [8:0] act;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [napt_pkg::IN_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    wire  s_tready;
    wire  [napt_pkg::OUT_W-1:0] m_tdata;
    wire  m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_valid = 1'b0;
    wire  cfg_ready;
    logic [napt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    napt_translation_table #(.ENTRIES(ENTRIES), .PORT_BASE(PORT_BASE)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow of the table and registers
    logic [31:0] gw_addr, subnet, mask, timeout;
    bit          tv_valid [ENTRIES];
    logic [31:0] tv_addr  [ENTRIES];
    logic [15:0] tv_port  [ENTRIES];
    logic [7:0]  tv_proto [ENTRIES];
    logic [31:0] tv_seen  [ENTRIES];
    logic [63:0] tv_pkts  [ENTRIES];
    logic [63:0] tv_bytes [ENTRIES];
    logic [8:0]  live;

    xlate_exp_t expected_beats[$];
    int  errors = 0;
    int  cycles = 0;
    int  hold_req = 0;
    bit  no_idle = 1'b0;
    logic [31:0] clock_ms = 32'd0;

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic int find_key(logic [31:0] a, logic [15:0] p, logic [7:0] pr);
        for (int i = 0; i < ENTRIES; i++)
            if (tv_valid[i] && tv_addr[i] == a && tv_port[i] == p && tv_proto[i] == pr)
                return i;
        return -1;
    endfunction

    function automatic int find_port(logic [15:0] p, logic [7:0] pr);
        logic [15:0] off;
        off = p - 16'(PORT_BASE);
        if (off < ENTRIES && tv_valid[off] && tv_proto[off] == pr) return int'(off);
        return -1;
    endfunction

    function automatic void touch(int s, logic [31:0] now, logic [15:0] len);
        tv_seen[s]  = now;
        tv_pkts[s]  = add_sat(tv_pkts[s], 64'd1);
        tv_bytes[s] = add_sat(tv_bytes[s], {48'd0, len});
    endfunction

    // expected result of one accepted beat; updates the shadow table
    function automatic res_t napt_predict(item_t it);
        res_t r;
        int   hit, dst, i;
        r = '0;
        if (it.cmd == napt_pkg::CMD_OUTBOUND || it.cmd == napt_pkg::CMD_INBOUND ||
            it.cmd == napt_pkg::CMD_HAIRPIN) begin
            r.osa = it.sa; r.osp = it.sp; r.oda = it.da; r.odp = it.dp;
        end
        case (it.cmd)
            napt_pkg::CMD_OUTBOUND: begin
                if ((it.sa & mask) != subnet) begin
                    r.status = napt_pkg::ST_REJECT;
                end else begin
                    hit = find_key(it.sa, it.sp, it.proto);
                    if (hit < 0) begin
                        for (i = 0; i < ENTRIES; i++)
                            if (!tv_valid[i]) break;
                        if (i < ENTRIES) begin
                            tv_valid[i] = 1'b1; tv_addr[i] = it.sa; tv_port[i] = it.sp;
                            tv_proto[i] = it.proto; tv_seen[i] = it.now;
                            tv_pkts[i] = 64'd1; tv_bytes[i] = {48'd0, it.len};
                            live++;
                            hit = i;
                        end
                    end else begin
                        touch(hit, it.now, it.len);
                    end
                    if (hit < 0) begin
                        r.status = napt_pkg::ST_FULL;
                    end else begin
                        r.osa = gw_addr;
                        r.osp = 16'(PORT_BASE + hit);
                    end
                end
            end
            napt_pkg::CMD_INBOUND: begin
                dst = find_port(it.dp, it.proto);
                if (it.da != gw_addr) r.status = napt_pkg::ST_REJECT;
                else if (dst < 0) r.status = napt_pkg::ST_NOMAP;
                else begin
                    touch(dst, it.now, it.len);
                    r.oda = tv_addr[dst];
                    r.odp = tv_port[dst];
                end
            end
            napt_pkg::CMD_SWEEP: begin
                for (i = 0; i < ENTRIES; i++)
                    if (tv_valid[i] && (it.now - tv_seen[i]) > timeout) begin
                        tv_valid[i] = 1'b0;
                        live--;
                        r.freed++;
                    end
            end
            napt_pkg::CMD_QUERY: begin
                hit = find_key(it.sa, it.sp, it.proto);
                if (hit < 0) r.status = napt_pkg::ST_NOMAP;
                else begin
                    r.osa = gw_addr;
                    r.osp = 16'(PORT_BASE + hit);
                end
            end
            napt_pkg::CMD_HAIRPIN: begin
                dst = find_port(it.dp, it.proto);
                if (it.da != gw_addr) r.status = napt_pkg::ST_REJECT;
                else if (dst < 0) r.status = napt_pkg::ST_NOMAP;
                else begin
                    hit = find_key(it.sa, it.sp, it.proto);
                    if (hit >= 0) begin
                        r.osa = gw_addr;
                        r.osp = 16'(PORT_BASE + hit);
                    end
                    r.oda = tv_addr[dst];
                    r.odp = tv_port[dst];
                end
            end
            napt_pkg::CMD_STATS: begin
                for (i = 0; i < ENTRIES; i++)
                    if (tv_valid[i]) begin
                        r.tpkts  = add_sat(r.tpkts, tv_pkts[i]);
                        r.tbytes = add_sat(r.tbytes, tv_bytes[i]);
                    end
            end
            default: ;
        endcase
        r.active = live;
        return r;
    endfunction

    function automatic row_t row(logic [2:0] cmd, logic [31:0] sa, logic [31:0] da,
                                 logic [15:0] sp, logic [15:0] dp, logic [7:0] pr,
                                 logic [15:0] len, logic [31:0] now,
                                 bit known, logic [1:0] st, logic [8:0] act);
        row_t w;
        w.it = '{pad: '0, now: now, len: len, proto: pr, dp: dp, sp: sp,
                 da: da, sa: sa, cmd: cmd};
        w.known = known; w.st = st; w.act = act;
        return w;
    endfunction

    // pick a live slot, or -1
    function automatic int pick_slot();
        int s;
        for (int k = 0; k < 8; k++) begin
            s = $urandom_range(0, (live + 8 > ENTRIES - 1) ? ENTRIES - 1 : live + 8);
            if (tv_valid[s]) return s;
        end
        return -1;
    endfunction

    function automatic logic [7:0] pool_proto();
        case ($urandom_range(0, 2))
            0: return 8'd6;
            1: return 8'd17;
            default: return 8'd1;
        endcase
    endfunction

    // random beat; fill mode pushes the table to full
    function automatic item_t gen_item(bit fill, int idx);
        item_t it;
        int    r, s;
        r = $urandom_range(0, 99);
        it = '0;
        it.sa = (subnet & mask) | ($urandom_range(0, 7) & ~mask);
        it.da = $urandom;
        it.sp = 16'(1000 + $urandom_range(0, 7));
        it.dp = 16'($urandom);
        it.proto = pool_proto();
        it.len = 16'($urandom);
        // time moves slowly, with occasional jumps and wraps
        if (!fill || idx > 290) begin
            case ($urandom_range(0, 29))
                0: clock_ms += $urandom;
                1, 2: clock_ms += 32'($urandom_range(0, 2000));
                default: clock_ms += 32'($urandom_range(0, 5));
            endcase
        end
        it.now = clock_ms;
        if (fill) begin
            if (r < 88) begin
                it.cmd = napt_pkg::CMD_OUTBOUND;
                it.sa = $urandom;
                it.sp = 16'($urandom);
            end else if (r < 93) it.cmd = napt_pkg::CMD_STATS;
            else if (r < 97 || idx <= 290) it.cmd = napt_pkg::CMD_QUERY;
            else it.cmd = napt_pkg::CMD_SWEEP;
            return it;
        end
        if (r < 35) begin
            it.cmd = napt_pkg::CMD_OUTBOUND;
            if ($urandom_range(0, 9) < 2) it.sa = $urandom;
        end else if (r < 75 && !(r >= 55 && r < 63)) begin
            it.cmd = (r < 55) ? napt_pkg::CMD_INBOUND :
                     (r < 68) ? napt_pkg::CMD_QUERY : napt_pkg::CMD_HAIRPIN;
            s = pick_slot();
            if (it.cmd != napt_pkg::CMD_QUERY) begin
                it.da = ($urandom_range(0, 99) < 85) ? gw_addr : $urandom;
                if (s >= 0 && $urandom_range(0, 99) < 80) it.dp = 16'(PORT_BASE + s);
                if (s >= 0 && $urandom_range(0, 99) < 85) it.proto = tv_proto[s];
                s = pick_slot();
            end
            if (s >= 0 && $urandom_range(0, 99) < 60) begin
                it.sa = tv_addr[s]; it.sp = tv_port[s]; it.proto = tv_proto[s];
            end
        end else if (r < 63) begin
            it.cmd = napt_pkg::CMD_SWEEP;
        end else if (r < 87) begin
            it.cmd = napt_pkg::CMD_HAIRPIN;
            it.da = gw_addr;
            s = pick_slot();
            if (s >= 0) begin
                it.dp = 16'(PORT_BASE + s); it.proto = tv_proto[s];
            end
        end else if (r < 92) begin
            it.cmd = napt_pkg::CMD_STATS;
        end else begin
            // noise: every field random
            it = {5'd0, 155'(({$urandom, $urandom, $urandom, $urandom, $urandom}))};
            it.cmd = 3'($urandom_range(0, 7));
        end
        return it;
    endfunction

    task automatic cfg_write(logic [napt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            napt_pkg::REG_GATEWAY: gw_addr = val;
            napt_pkg::REG_SUBNET:  subnet  = val;
            napt_pkg::REG_MASK:    mask    = val;
            napt_pkg::REG_TIMEOUT: timeout = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_beat(item_t it, bit known, logic [1:0] st, logic [8:0] act);
        xlate_exp_t e;
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
        e.r = napt_predict(it); e.known = known; e.st = st; e.act = act;
        expected_beats = {expected_beats, e};
        // sender gap after the beat
        gap = 0;
        if (!no_idle) begin
            case ($urandom_range(0, 19))
                0: gap = $urandom_range(20, 80);
                1, 2, 3, 4: gap = $urandom_range(1, 3);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic run_phase(logic [31:0] g, logic [31:0] sn, logic [31:0] mk,
                             logic [31:0] to, int n, bit fill, bit quiet, bit stall);
        settle();
        cfg_write(napt_pkg::REG_GATEWAY, g);
        cfg_write(napt_pkg::REG_SUBNET, sn);
        cfg_write(napt_pkg::REG_MASK, mk);
        cfg_write(napt_pkg::REG_TIMEOUT, to);
        no_idle = quiet;
        for (int i = 0; i < n; i++) begin
            if (stall && i == 40) hold_req = 3000;
            send_beat(gen_item(fill, i), 1'b0, napt_pkg::ST_OK, '0);
        end
        no_idle = 1'b0;
    endtask

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        res_t got;
        xlate_exp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_beats.size() == 0) begin
                report("unexpected beat", 64'(got.status), 64'd0);
            end else begin
                e = expected_beats.pop_front();
                if (got.status != e.r.status)
                    report("status", 64'(got.status), 64'(e.r.status));
                if (got.osa != e.r.osa) report("out_src_addr", 64'(got.osa), 64'(e.r.osa));
                if (got.osp != e.r.osp) report("out_src_port", 64'(got.osp), 64'(e.r.osp));
                if (got.oda != e.r.oda) report("out_dst_addr", 64'(got.oda), 64'(e.r.oda));
                if (got.odp != e.r.odp) report("out_dst_port", 64'(got.odp), 64'(e.r.odp));
                if (got.active != e.r.active)
                    report("active_entries", 64'(got.active), 64'(e.r.active));
                if (got.tpkts != e.r.tpkts) report("total_packets", got.tpkts, e.r.tpkts);
                if (got.tbytes != e.r.tbytes) report("total_bytes", got.tbytes, e.r.tbytes);
                if (got.freed != e.r.freed)
                    report("freed_count", 64'(got.freed), 64'(e.r.freed));
                if (e.known && got.status != e.st)
                    report("directed status", 64'(got.status), 64'(e.st));
                if (e.known && got.active != e.act)
                    report("directed active", 64'(got.active), 64'(e.act));
            end
        end
    end

    // receiver backpressure, long hold-off on request
    initial begin
        int gap, hold;
        gap = 0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle) begin
                    case ($urandom_range(0, 49))
                        0: gap = $urandom_range(20, 60);
                        1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: gap = $urandom_range(1, 3);
                        default: gap = 0;
                    endcase
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("napt_translation_table verification failed");
            $finish;
        end
    end

    row_t dir_rows[18];

    initial begin
        gw_addr = '0; subnet = '0; mask = '0; timeout = napt_pkg::TIMEOUT_RESET;
        live = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            tv_valid[i] = 1'b0; tv_addr[i] = '0; tv_port[i] = '0; tv_proto[i] = '0;
            tv_seen[i] = '0; tv_pkts[i] = '0; tv_bytes[i] = '0;
        end
        // directed rows under reset registers: everything is inside, gateway 0
        dir_rows = '{
            row(napt_pkg::CMD_STATS, 0, 0, 0, 0, 0, 0, 0, 1, napt_pkg::ST_OK, 0),
            row(napt_pkg::CMD_QUERY, 32'h0a000001, 0, 80, 0, 6, 0, 0,
                1, napt_pkg::ST_NOMAP, 0),
            row(napt_pkg::CMD_INBOUND, 0, 0, 0, 16'd1024, 6, 100, 0,
                1, napt_pkg::ST_NOMAP, 0),
            row(napt_pkg::CMD_INBOUND, 0, 5, 0, 16'd1024, 6, 100, 0,
                1, napt_pkg::ST_REJECT, 0),
            row(napt_pkg::CMD_OUTBOUND, '1, '1, '1, '1, '1, '1, '1, 1, napt_pkg::ST_OK, 1),
            row(napt_pkg::CMD_OUTBOUND, 0, 0, 0, 0, 0, 0, 0, 1, napt_pkg::ST_OK, 2),
            row(napt_pkg::CMD_OUTBOUND, '1, 7, '1, 9, '1, 40, 3, 1, napt_pkg::ST_OK, 2),
            row(napt_pkg::CMD_QUERY, '1, 0, '1, 0, '1, 0, 0, 1, napt_pkg::ST_OK, 2),
            row(napt_pkg::CMD_INBOUND, 7, 0, 55, 16'd1024, '1, 64, 4,
                1, napt_pkg::ST_OK, 2),
            row(napt_pkg::CMD_INBOUND, 7, 0, 55, 16'd1024, 6, 64, 4,
                1, napt_pkg::ST_NOMAP, 2),
            row(napt_pkg::CMD_HAIRPIN, 0, 0, 0, 16'd1025, 0, 9, 5, 1, napt_pkg::ST_OK, 2),
            row(napt_pkg::CMD_HAIRPIN, 0, 1, 0, 16'd1025, 0, 9, 5,
                1, napt_pkg::ST_REJECT, 2),
            row(napt_pkg::CMD_HAIRPIN, 123, 0, 77, 16'd1025, 0, 9, 5,
                1, napt_pkg::ST_OK, 2),
            row(CMD_SPARE_A, '1, '1, '1, '1, '1, '1, '1, 1, napt_pkg::ST_OK, 2),
            row(CMD_SPARE_B, 5, 6, 7, 8, 9, 10, 11, 1, napt_pkg::ST_OK, 2),
            row(napt_pkg::CMD_STATS, 0, 0, 0, 0, 0, 0, 0, 1, napt_pkg::ST_OK, 2),
            row(napt_pkg::CMD_SWEEP, 0, 0, 0, 0, 0, 0, 5, 1, napt_pkg::ST_OK, 2),
            row(napt_pkg::CMD_SWEEP, 0, 0, 0, 0, 0, 0, 32'd300006, 1, napt_pkg::ST_OK, 0)
        };
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i].it, dir_rows[i].known, dir_rows[i].st, dir_rows[i].act);

        clock_ms = 32'd400000;
        run_phase(32'hc0a80001, 32'h0a000000, 32'hff000000, 32'd1000, 300, 0, 0, 1);
        run_phase(32'h00000000, 32'h00000000, 32'h00000000, 32'd0, 320, 1, 0, 0);
        run_phase(32'hffffffff, 32'h0a000100, 32'hffffffff, 32'hffffffff, 150, 0, 1, 0);
        run_phase(32'h12345678, 32'hc0a80000, 32'hffff0000, 32'd50, 230, 0, 0, 0);

        settle();
        if (errors == 0) begin
            $display("napt_translation_table verification clean");
        end else begin
            $display("napt_translation_table verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
design/napt_pkg.sv
design/napt_ctrl.sv
design/napt_dpath.sv
design/napt_translation_table.sv
dv/tb_napt_translation_table.sv
